FILE: rtl/dhkt_pkg.sv
// Shared types, codes and defaults for the double-hashed key table.
`timescale 1ns / 1ps

package dhkt_pkg;

  // Field widths fixed by the transaction format
  localparam int KEY_W    = 32;
  localparam int HANDLE_W = 32;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;

  // Default geometry
  localparam int DEF_SLOTS   = 64;
  localparam int DEF_RETRIES = 4;
  localparam int DEF_BANKS   = 4;

  // Opcodes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_MISSING = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]     opcode;
    logic [KEY_W-1:0]    window_key;
    logic [HANDLE_W-1:0] handle_value;
  } dhkt_in_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] found_value;
    logic [STATUS_W-1:0] status;
  } dhkt_out_t;

  // One slot of table memory
  typedef struct packed {
    logic                valid;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
  } dhkt_slot_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_READ,
    S_CHECK,
    S_DONE
  } dhkt_state_t;

endpackage

FILE: rtl/double_hash_key_table_unit.sv
// Top level of the double-hashed key-to-handle table.
`timescale 1ns / 1ps

// After reset the block sweeps its slot memory once to clear every valid mark,
// one slot a cycle over all SLOTS x BANKS slots (256 at the defaults); busy
// stays high throughout. An operation is taken when start is high and busy is
// low. The key residues come from one shared multiplier by reciprocal
// multiplication, then slots are probed one after another through the one read
// port of the slot memory, each probe a read, then a compare and write back, up to
// BANKS x (RETRIES+1) probes. The result is on out_data with out_valid high for
// exactly one cycle (an unused opcode skips the hash and probes and answers at
// the next edge); busy falls as the result is taken, so the next transaction
// can be taken at the edge after. There is no back-pressure on the result
// side: the receiver must take it in that cycle.
module double_hash_key_table_unit #(
  parameter int SLOTS   = dhkt_pkg::DEF_SLOTS,
  parameter int RETRIES = dhkt_pkg::DEF_RETRIES,
  parameter int BANKS   = dhkt_pkg::DEF_BANKS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  dhkt_pkg::dhkt_in_t  in_data,
  output logic                out_valid,
  output dhkt_pkg::dhkt_out_t out_data
);
  import dhkt_pkg::*;

  localparam int TOTAL = SLOTS * BANKS;
  localparam int SW    = $clog2(SLOTS);
  localparam int AW    = $clog2(TOTAL);
  localparam int PW    = $clog2(RETRIES + 2);
  localparam int BW    = $clog2(BANKS + 1);
  localparam logic [AW-1:0] SLOTS_A    = AW'(SLOTS);
  localparam logic [AW-1:0] LAST_SLOT  = AW'(TOTAL - 1);
  localparam logic [SW:0]   SLOTS_W    = (SW+1)'(SLOTS);
  localparam logic [PW-1:0] LAST_PROBE = PW'(RETRIES);
  localparam logic [BW-1:0] LAST_BANK  = BW'(BANKS - 1);

  dhkt_state_t state_r, state_nxt;
  logic [OP_W-1:0]     op_r, op_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [HANDLE_W-1:0] handle_r, handle_nxt;
  logic [SW-1:0]       pos_r, pos_nxt;
  logic [AW-1:0]       base_r, base_nxt;
  logic [BW-1:0]       bank_r, bank_nxt;
  logic [PW-1:0]       probe_r, probe_nxt;
  logic [AW-1:0]       clr_r, clr_nxt;
  dhkt_out_t           res_r, res_nxt;

  logic          hash_start;
  logic          hash_done;
  logic [SW-1:0] home;
  logic [SW-1:0] step;

  logic [AW-1:0] addr;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  dhkt_slot_t    mem_wdata;
  dhkt_slot_t    rdata_r;
  dhkt_slot_t    mem [TOTAL];

  logic          hit;
  logic [SW:0]   pos_sum;
  logic [SW-1:0] pos_wrap;

  dhkt_residue #(
    .SLOTS(SLOTS)
  ) u_residue (
    .clk  (clk),
    .rst_n(rst_n),
    .start(hash_start),
    .key  (key_nxt),
    .done (hash_done),
    .home (home),
    .step (step)
  );

  assign addr = base_r + AW'(pos_r);

  // Next probe position within the bank, one compare and subtract
  assign pos_sum  = {1'b0, pos_r} + {1'b0, step};
  assign pos_wrap = (pos_sum >= SLOTS_W) ? SW'(pos_sum - SLOTS_W) : pos_sum[SW-1:0];

  // Insert wants a free slot; lookup and remove want a matching key
  assign hit = (op_r == OP_INSERT) ? !rdata_r.valid
                                   : (rdata_r.valid && (rdata_r.key == key_r));

  // Slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_r <= mem[addr];
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  // Transaction and probe registers
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    key_r    <= key_nxt;
    handle_r <= handle_nxt;
    pos_r    <= pos_nxt;
    base_r   <= base_nxt;
    bank_r   <= bank_nxt;
    probe_r  <= probe_nxt;
    res_r    <= res_nxt;
  end

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    key_nxt    = key_r;
    handle_nxt = handle_r;
    pos_nxt    = pos_r;
    base_nxt   = base_r;
    bank_nxt   = bank_r;
    probe_nxt  = probe_r;
    clr_nxt    = clr_r;
    res_nxt    = res_r;
    hash_start = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = addr;
    mem_wdata  = rdata_r;

    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        if (clr_r == LAST_SLOT) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (start) begin
          op_nxt     = in_data.opcode;
          key_nxt    = in_data.window_key;
          handle_nxt = in_data.handle_value;
          res_nxt    = '{found_value: '0, status: STAT_OK};
          if (in_data.opcode == OP_NONE) begin
            state_nxt = S_DONE;
          end else begin
            hash_start = 1'b1;
            state_nxt  = S_HASH;
          end
        end
      end

      S_HASH: begin
        if (hash_done) begin
          pos_nxt   = home;
          base_nxt  = '0;
          bank_nxt  = '0;
          probe_nxt = '0;
          state_nxt = S_READ;
        end
      end

      S_READ: begin
        state_nxt = S_CHECK;
      end

      S_CHECK: begin
        if (hit) begin
          state_nxt = S_DONE;
          priority if (op_r == OP_INSERT) begin
            mem_we    = 1'b1;
            mem_wdata = '{valid: 1'b1, key: key_r, handle: handle_r};
          end else if (op_r == OP_REMOVE) begin
            mem_we          = 1'b1;
            mem_wdata.valid = 1'b0;
          end else begin
            res_nxt.found_value = rdata_r.handle;
          end
        end else if (probe_r == LAST_PROBE) begin
          if (bank_r == LAST_BANK) begin
            res_nxt.status = (op_r == OP_INSERT) ? STAT_FULL : STAT_MISSING;
            state_nxt      = S_DONE;
          end else begin
            bank_nxt  = bank_r + 1'b1;
            base_nxt  = base_r + SLOTS_A;
            pos_nxt   = home;
            probe_nxt = '0;
            state_nxt = S_READ;
          end
        end else begin
          probe_nxt = probe_r + 1'b1;
          pos_nxt   = pos_wrap;
          state_nxt = S_READ;
        end
      end

      S_DONE: begin
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);
  assign out_data  = res_r;

endmodule

FILE: rtl/dhkt_residue.sv
// Iterative unit forming key mod SLOTS (home slot) and key mod (SLOTS-2) + 1 (probe step).
`timescale 1ns / 1ps

module dhkt_residue #(
  parameter int SLOTS = dhkt_pkg::DEF_SLOTS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [dhkt_pkg::KEY_W-1:0]    key,
  output logic                          done,
  output logic [$clog2(SLOTS)-1:0]      home,
  output logic [$clog2(SLOTS)-1:0]      step
);
  import dhkt_pkg::*;

  localparam int SW     = $clog2(SLOTS);
  localparam int PROD_W = 2 * KEY_W;
  // floor(2^32 / m): the quotient estimate is exact or one low
  localparam logic [KEY_W-1:0] RECIP_HOME = KEY_W'((64'd1 << KEY_W) / SLOTS);
  localparam logic [KEY_W-1:0] RECIP_STEP = KEY_W'((64'd1 << KEY_W) / (SLOTS - 2));
  localparam logic [KEY_W-1:0] DIV_HOME   = KEY_W'(SLOTS);
  localparam logic [KEY_W-1:0] DIV_STEP   = KEY_W'(SLOTS - 2);
  localparam logic [SW:0]      MOD_HOME   = (SW+1)'(SLOTS);
  localparam logic [SW:0]      MOD_STEP   = (SW+1)'(SLOTS - 2);

  // Sequencer phases, one multiply each
  localparam logic [2:0] PH_HOME_EST  = 3'd0;  // key x home reciprocal
  localparam logic [2:0] PH_HOME_BACK = 3'd1;  // quotient x SLOTS
  localparam logic [2:0] PH_STEP_EST  = 3'd2;  // home settles; key x step reciprocal
  localparam logic [2:0] PH_STEP_BACK = 3'd3;  // quotient x (SLOTS-2)
  localparam logic [2:0] PH_STEP_FIX  = 3'd4;  // step residue settles

  logic [KEY_W-1:0]  key_r;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [KEY_W-1:0]  mul_a;
  logic [KEY_W-1:0]  mul_b;
  logic [SW:0]       mod_sel;
  logic [SW:0]       diff;
  logic [SW-1:0]     res_fix;
  logic [SW-1:0]     home_r;
  logic [SW-1:0]     rem_r;
  logic [2:0]        cnt_r;
  logic              run_r;
  logic              done_r;

  // Shared multiplier, operands chosen by phase
  always_comb begin
    unique case (cnt_r)
      PH_HOME_EST: begin
        mul_a = key_r;
        mul_b = RECIP_HOME;
      end
      PH_HOME_BACK: begin
        mul_a = prod_r[PROD_W-1:KEY_W];
        mul_b = DIV_HOME;
      end
      PH_STEP_EST: begin
        mul_a = key_r;
        mul_b = RECIP_STEP;
      end
      PH_STEP_BACK: begin
        mul_a = prod_r[PROD_W-1:KEY_W];
        mul_b = DIV_STEP;
      end
      default: begin
        mul_a = key_r;
        mul_b = '0;
      end
    endcase
    prod_nxt = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // Remainder estimate is below twice the modulus: low bits and one subtract
  assign mod_sel = (cnt_r == PH_STEP_EST) ? MOD_HOME : MOD_STEP;
  assign diff    = key_r[SW:0] - prod_r[SW:0];
  assign res_fix = (diff >= mod_sel) ? SW'(diff - mod_sel) : diff[SW-1:0];

  // Sequencer: five phases per key
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= run_r && (cnt_r == PH_STEP_FIX);
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == PH_STEP_FIX) run_r <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      key_r <= key;
    end else if (run_r) begin
      prod_r <= prod_nxt;
      if (cnt_r == PH_STEP_EST) home_r <= res_fix;
      if (cnt_r == PH_STEP_FIX) rem_r  <= res_fix;
    end
  end

  assign done = done_r;
  assign home = home_r;
  assign step = rem_r + 1'b1;

endmodule

FILE: rtl/dhkt_checker.sv
// Port-level checks on the key table, bound to the top level.
`timescale 1ns / 1ps

module dhkt_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input dhkt_pkg::dhkt_out_t out_data
);
  import dhkt_pkg::*;

  // An accepted transaction makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("block not busy after accepting a transaction");

  // A result strobe lasts one cycle and is followed by readiness
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy)
    else $error("result strobe longer than one cycle or block stays busy");

  // Results come only while a transaction is held
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe while idle");

  // A failed transaction returns a zero handle; status is a known code
  a_status_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == STAT_OK || out_data.status == STAT_MISSING ||
                   out_data.status == STAT_FULL) &&
                  (out_data.status == STAT_OK || out_data.found_value == '0))
    else $error("bad status code or handle returned on failure");

endmodule

bind double_hash_key_table_unit dhkt_checker u_dhkt_checker (.*);

FILE: tb/sv/testbench.sv
// Self-checking testbench for the double-hashed key-to-handle table.
`timescale 1ns / 1ps

module testbench;
  import dhkt_pkg::*;

  localparam int TABLE_SIZE = DEF_SLOTS * DEF_BANKS;
  // Two keys that differ by a multiple of this share home slot and step
  localparam int unsigned FAMILY_PERIOD = DEF_SLOTS * (DEF_SLOTS - 2) / 2;
  localparam int unsigned FAMILY_MAX_N  = 32'hFFFF_FFFF / FAMILY_PERIOD - 1;
  localparam int unsigned SETTLE_CYCLES = 60;
  localparam int unsigned RANDOM_OPS    = 1380;

  // Mirror of the slot table; predicts the reply to each accepted transaction
  class handle_table_scoreboard;
    bit              slot_used[TABLE_SIZE];
    logic [31:0]     slot_key[TABLE_SIZE];
    logic [31:0]     slot_handle[TABLE_SIZE];
    dhkt_out_t       awaited_replies[$];
    int unsigned     mismatches;

    function new();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      mismatches = 0;
    endfunction

    // Flat slot index of one probe
    function int unsigned probe_index(logic [31:0] key, int unsigned bank,
                                      int unsigned probe);
      longint unsigned home;
      longint unsigned stride;
      home   = key % DEF_SLOTS;
      stride = key % (DEF_SLOTS - 2) + 1;
      return bank * DEF_SLOTS + int'((home + probe * stride) % DEF_SLOTS);
    endfunction

    function void record_operation(dhkt_in_t op);
      dhkt_out_t   reply;
      int unsigned s;
      bit          hit;
      reply.found_value = '0;
      reply.status      = STAT_OK;
      hit               = 1'b0;
      case (op.opcode)
        OP_INSERT: begin
          for (int b = 0; b < DEF_BANKS; b++) begin
            for (int i = 0; i <= DEF_RETRIES; i++) begin
              s = probe_index(op.window_key, b, i);
              if (!hit && !slot_used[s]) begin
                slot_used[s]   = 1'b1;
                slot_key[s]    = op.window_key;
                slot_handle[s] = op.handle_value;
                hit            = 1'b1;
              end
            end
          end
          reply.status = hit ? STAT_OK : STAT_FULL;
        end
        OP_LOOKUP, OP_REMOVE: begin
          for (int b = 0; b < DEF_BANKS; b++) begin
            for (int i = 0; i <= DEF_RETRIES; i++) begin
              s = probe_index(op.window_key, b, i);
              if (!hit && slot_used[s] && slot_key[s] == op.window_key) begin
                if (op.opcode == OP_LOOKUP) reply.found_value = slot_handle[s];
                else slot_used[s] = 1'b0;
                hit = 1'b1;
              end
            end
          end
          reply.status = hit ? STAT_OK : STAT_MISSING;
        end
        default: ;  // unused opcode: no state change, plain OK
      endcase
      awaited_replies.push_back(reply);
    endfunction

    function void report(string what, logic [31:0] expd, logic [31:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("MISMATCH %s: expected %h, got %h", what, expd, got);
    endfunction

    function void check_reply(dhkt_out_t got);
      dhkt_out_t expd;
      if (awaited_replies.size() == 0) begin
        report("reply with nothing outstanding", '0, {got.found_value});
        return;
      end
      expd = awaited_replies.pop_front();
      if (got.found_value !== expd.found_value)
        report("found_value", expd.found_value, got.found_value);
      if (got.status !== expd.status)
        report("status", {30'd0, expd.status}, {30'd0, got.status});
    endfunction

    function bit outstanding();
      return awaited_replies.size() != 0;
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  dhkt_in_t   in_data;
  logic       out_valid;
  dhkt_out_t  out_data;

  handle_table_scoreboard table_sb;
  logic [31:0]            key_pool[16];
  bit                     no_idle;

  double_hash_key_table_unit #(
    .SLOTS  (DEF_SLOTS),
    .RETRIES(DEF_RETRIES),
    .BANKS  (DEF_BANKS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  // 20 ns clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Run limit, well beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("double_hash_key_table_unit verification failed");
    $finish;
  end

  // Sample replies and accepted transactions on the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) table_sb.check_reply(out_data);
      if (start && !busy) table_sb.record_operation(in_data);
    end
  end

  // Present one transaction and hold it until the block takes it
  task automatic issue_op(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                          input logic [HANDLE_W-1:0] hdl);
    int unsigned gap;
    bit          wait_idle;
    dhkt_in_t    req;
    gap       = no_idle ? 0 : $urandom_range(0, 8);
    wait_idle = no_idle ? 1'b0 : 1'($urandom_range(0, 1));
    req.opcode       = op;
    req.window_key   = key;
    req.handle_value = hdl;
    @(negedge clk);
    if (gap > 0 || wait_idle) begin
      start <= 1'b0;
      if (wait_idle) begin
        do @(negedge clk); while (busy);
      end
      repeat (gap) @(negedge clk);
    end
    in_data <= req;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Hold off until every reply is in
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (table_sb.outstanding()) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Fresh key pool: two families sharing a probe sequence, plus free keys
  task automatic refill_pool();
    int unsigned base;
    for (int f = 0; f < 2; f++) begin
      base = $urandom_range(0, FAMILY_PERIOD - 1);
      for (int k = 0; k < 4; k++)
        key_pool[f * 4 + k] = base + $urandom_range(0, FAMILY_MAX_N) * FAMILY_PERIOD;
    end
    for (int k = 8; k < 16; k++) key_pool[k] = $urandom;
  endtask

  initial begin
    logic [OP_W-1:0]     op;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] hdl;
    int unsigned         pick;

    table_sb = new();
    no_idle  = 1'b0;
    rst_n    = 1'b0;
    start    = 1'b0;
    in_data  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, every opcode, misses
    issue_op(OP_INSERT, 32'h0000_0000, 32'h0000_0000);
    issue_op(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue_op(OP_LOOKUP, 32'h0000_0000, 32'h1234_5678);
    issue_op(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    issue_op(OP_LOOKUP, 32'h8000_0001, 32'h0);
    issue_op(OP_REMOVE, 32'h0000_0000, 32'hFFFF_FFFF);
    issue_op(OP_LOOKUP, 32'h0000_0000, 32'h0);
    issue_op(OP_REMOVE, 32'h0000_0000, 32'h0);
    issue_op(OP_NONE,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Key 31: step 32, so each bank revisits two slots; duplicates and the held key FFFF_FFFF
    // (bank 0, slot 63) fill them, so the eighth and ninth inserts find the table full
    for (int n = 0; n < 9; n++) issue_op(OP_INSERT, 32'd31, 32'hA000_0000 + n);
    issue_op(OP_LOOKUP, 32'd31, 32'h0);
    issue_op(OP_REMOVE, 32'd31, 32'h0);
    issue_op(OP_LOOKUP, 32'd31, 32'h0);
    drain();

    // Random: small key pools so that hits, duplicates and full banks occur
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n % 200 == 0) refill_pool();
      no_idle = (n % 300) >= 240;
      if (n == RANDOM_OPS / 2) drain();
      pick = $urandom_range(0, 99);
      if (pick < 36)      op = OP_INSERT;
      else if (pick < 60) op = OP_LOOKUP;
      else if (pick < 95) op = OP_REMOVE;
      else                op = OP_NONE;
      key = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, 15)];
      pick = $urandom_range(0, 9);
      if (pick == 0)      hdl = 32'h0000_0000;
      else if (pick == 1) hdl = 32'hFFFF_FFFF;
      else                hdl = $urandom;
      issue_op(op, key, hdl);
    end

    // Let the last replies arrive and watch for strays
    @(negedge clk);
    start <= 1'b0;
    while (table_sb.outstanding()) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (table_sb.mismatches == 0 && !table_sb.outstanding())
      $display("double_hash_key_table_unit verification clean");
    else
      $display("double_hash_key_table_unit verification failed");
    $finish;
  end

endmodule

FILE: double_hash_key_table_unit.f
rtl/dhkt_pkg.sv
rtl/dhkt_residue.sv
rtl/double_hash_key_table_unit.sv
rtl/dhkt_checker.sv
tb/sv/testbench.sv
